### hw/rtl/nlc_pkg.sv
`default_nettype none
package nlc_pkg;

  localparam int LANDMARKS_MAX = 64;
  localparam int DIMS_MAX      = 32;
  localparam int COORD_BITS    = 16;

  localparam int LM_IDX_W = $clog2(LANDMARKS_MAX);
  localparam int DIM_W    = $clog2(DIMS_MAX);
  localparam int NA_W     = $clog2(LANDMARKS_MAX + 1);
  localparam int ND_W     = $clog2(DIMS_MAX + 1);

  // register and field widths fixed by the interface
  localparam int CFG_DIMS_W  = 6;
  localparam int CFG_LMS_W   = 7;
  localparam int ALPHA_W     = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int COLOR_W     = 24;
  localparam int PIDX_W      = 20;
  localparam int DIST_W      = 40;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 104;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SAT_W  = (SQ_W > DIST_W) ? SQ_W : DIST_W;

  // from the last coordinate of a point to the result capture the sweep spans:
  // two pipeline stages, the cells of the argmin chain, colour RAM read, margin
  localparam int SWEEP_LAST = LANDMARKS_MAX + 4;
  localparam int CNT_W      = $clog2(SWEEP_LAST + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD_COORD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_COLOR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POINT      = 2'd2;

  typedef enum logic [1:0] {
    CFG_DIMS  = 2'd0,
    CFG_LMS   = 2'd1,
    CFG_ALPHA = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SWEEP,
    ST_OUT
  } state_t;

  // broadcast from the top level to every landmark cell
  typedef struct packed {
    logic                         wr_en;
    logic [LM_IDX_W-1:0]          lm;
    logic [DIM_W-1:0]             dim;
    logic signed [COORD_BITS-1:0] wr_data;
    logic                         s1_vld;
    logic signed [COORD_BITS-1:0] s1_cv;
    logic                         s2_vld;
    logic                         s2_first;
    logic                         clr;
    logic [NA_W-1:0]              na;
  } cell_ctl_t;

  // best candidate handed from cell to cell
  typedef struct packed {
    logic                vld;
    logic [LM_IDX_W-1:0] idx;
    logic [DIST_W-1:0]   dist_val;
  } best_t;

  function automatic logic [DIST_W-1:0] sq_sat(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        ad;
    logic [SQ_W-1:0]          sq;
    d  = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    ad = d[DIFF_W-1] ? $unsigned(-d) : $unsigned(d);
    sq = SQ_W'(ad) * SQ_W'(ad);
    return (SAT_W'(sq) > SAT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sq);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/nlc_ram.sv
`default_nettype none
module nlc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/nlc_cell.sv
`default_nettype none
module nlc_cell import nlc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [LM_IDX_W-1:0] cell_idx,
  input  wire cell_ctl_t           ctl,
  input  wire best_t               best_in,
  output best_t                    best_out
);

  logic [COORD_BITS-1:0] lm_coord;
  logic [DIST_W-1:0]     sq_r;
  logic [DIST_W-1:0]     dist_r, dist_nxt;
  logic [DIST_W:0]       sum;
  logic                  active, take;
  best_t                 best_r, best_nxt;

  nlc_ram #(.WIDTH(COORD_BITS), .DEPTH(DIMS_MAX)) u_coord_ram (
    .clk   (clk),
    .we    (ctl.wr_en && (ctl.lm == cell_idx)),
    .waddr (ctl.dim),
    .wdata (ctl.wr_data),
    .raddr (ctl.dim),
    .rdata (lm_coord)
  );

  always_ff @(posedge clk) begin
    if (ctl.s1_vld) begin
      sq_r <= sq_sat($signed(lm_coord), ctl.s1_cv);
    end
  end

  assign sum = {1'b0, dist_r} + {1'b0, sq_r};

  always_comb begin
    dist_nxt = dist_r;
    if (ctl.clr) begin
      dist_nxt = '0;
    end else if (ctl.s2_vld) begin
      if (ctl.s2_first) begin
        dist_nxt = sq_r;
      end else if (sum > {1'b0, DIST_MAX}) begin
        dist_nxt = DIST_MAX;
      end else begin
        dist_nxt = sum[DIST_W-1:0];
      end
    end
  end

  // strict compare: on a tie the lower index further up the chain wins
  assign active = ({1'b0, cell_idx} < (LM_IDX_W + 1)'(ctl.na));
  assign take   = active && (!best_in.vld || (dist_r < best_in.dist_val));

  always_comb begin
    best_nxt = best_in;
    if (take) begin
      best_nxt.vld      = 1'b1;
      best_nxt.idx      = cell_idx;
      best_nxt.dist_val = dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r     <= '0;
      best_r.vld <= 1'b0;
    end else begin
      dist_r     <= dist_nxt;
      best_r.vld <= best_nxt.vld;
    end
    best_r.idx      <= best_nxt.idx;
    best_r.dist_val <= best_nxt.dist_val;
  end

  assign best_out = best_r;

endmodule
`default_nettype wire

### hw/rtl/nearest_landmark_classifier_top.sv
// Nearest-landmark classifier. Landmark coordinates (in_tuser = 0) and colours (in_tuser = 1)
// are loaded one value per request; each of the 64 landmark cells keeps its own coordinate RAM
// and squared-distance sum. Point coordinates (in_tuser = 2) are then sent in dimension order,
// one per cycle while in_tready is high; dimension 0 restarts every sum. The last
// coordinate of a point (dim_index = dims_in_use - 1) holds in_tready low through the
// coordinate read and square, the walk of the running minimum down the cell chain, one
// register per cell, and then the colour RAM read. The result is then
// held on the out_ channel and in_tready stays low until it is taken. Ties go to the lower
// landmark index; out_tuser flags the case of no active landmark. Configure only while idle.
`default_nettype none
module nearest_landmark_classifier_top import nlc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // landmark_index, dim_index, coord_value, color_rgb, point_index, 1 pad bit
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  wire logic [MODE_W-1:0]      in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // point_index_out, nearest_index, nearest_color, alpha_out, nearest_distance, 6 pad bits
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // no_landmarks
  output logic [0:0]                  out_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [LM_IDX_W-1:0]          in_lm;
  logic [DIM_W-1:0]             in_dim;
  logic signed [COORD_BITS-1:0] in_cv;
  logic [COLOR_W-1:0]           in_color;
  logic [PIDX_W-1:0]            in_pidx;

  assign in_lm    = in_tdata[5:0];
  assign in_dim   = in_tdata[10:6];
  assign in_cv    = $signed(in_tdata[26:11]);
  assign in_color = in_tdata[50:27];
  assign in_pidx  = in_tdata[70:51];

  logic [CFG_DIMS_W-1:0] dims_r;
  logic [CFG_LMS_W-1:0]  lms_r;
  logic [ALPHA_W-1:0]    alpha_r;
  logic [ND_W-1:0]       nd;
  logic [NA_W-1:0]       na;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r  <= CFG_DIMS_W'(2);
      lms_r   <= '0;
      alpha_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIMS:  dims_r  <= cfg_wdata[CFG_DIMS_W-1:0];
        CFG_LMS:   lms_r   <= cfg_wdata[CFG_LMS_W-1:0];
        CFG_ALPHA: alpha_r <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the registers to the supported range
  always_comb begin
    if (dims_r == '0) begin
      nd = ND_W'(1);
    end else if (ND_W'(dims_r) > ND_W'(DIMS_MAX)) begin
      nd = ND_W'(DIMS_MAX);
    end else begin
      nd = ND_W'(dims_r);
    end
    if (NA_W'(lms_r) > NA_W'(LANDMARKS_MAX)) begin
      na = NA_W'(LANDMARKS_MAX);
    end else begin
      na = NA_W'(lms_r);
    end
  end

  logic accept, is_point, is_last;

  assign accept   = in_tvalid && in_tready;
  assign is_point = accept && (in_tuser == MODE_POINT) && (ND_W'(in_dim) < nd);
  assign is_last  = is_point && (ND_W'(in_dim) == (nd - ND_W'(1)));

  // point pipeline: stage 1 has the coordinate RAM data, stage 2 the square
  logic                         s1_vld_r, s1_first_r, s2_vld_r, s2_first_r;
  logic signed [COORD_BITS-1:0] s1_cv_r;
  logic [PIDX_W-1:0]            pidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= is_point;
      s2_vld_r <= s1_vld_r;
    end
    s1_cv_r    <= in_cv;
    s1_first_r <= (in_dim == '0);
    s2_first_r <= s1_first_r;
    if (is_last) begin
      pidx_r <= in_pidx;
    end
  end

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             capture;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN:   if (is_last) state_nxt = ST_SWEEP;
      ST_SWEEP: if (cnt_r == CNT_W'(SWEEP_LAST)) state_nxt = ST_OUT;
      ST_OUT:   if (out_tready) state_nxt = ST_RUN;
      default:  state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    capture    = 1'b0;
    cnt_nxt    = '0;
    case (state_r)
      ST_RUN: in_tready = 1'b1;
      ST_SWEEP: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        capture = (cnt_r == CNT_W'(SWEEP_LAST));
      end
      ST_OUT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  cell_ctl_t ctl;
  best_t     chain [LANDMARKS_MAX+1];

  always_comb begin
    ctl.wr_en    = accept && (in_tuser == MODE_LOAD_COORD);
    ctl.lm       = in_lm;
    ctl.dim      = in_dim;
    ctl.wr_data  = in_cv;
    ctl.s1_vld   = s1_vld_r;
    ctl.s1_cv    = s1_cv_r;
    ctl.s2_vld   = s2_vld_r;
    ctl.s2_first = s2_first_r;
    ctl.clr      = capture;
    ctl.na       = na;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < LANDMARKS_MAX; g++) begin : g_cell
    nlc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (LM_IDX_W'(g)),
      .ctl      (ctl),
      .best_in  (chain[g]),
      .best_out (chain[g+1])
    );
  end

  logic [COLOR_W-1:0] color_rd;

  nlc_ram #(.WIDTH(COLOR_W), .DEPTH(LANDMARKS_MAX)) u_color_ram (
    .clk   (clk),
    .we    (accept && (in_tuser == MODE_LOAD_COLOR)),
    .waddr (in_lm),
    .wdata (in_color),
    .raddr (chain[LANDMARKS_MAX].idx),
    .rdata (color_rd)
  );

  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_none_r;
  best_t                  best;

  assign best = chain[LANDMARKS_MAX];

  always_ff @(posedge clk) begin
    if (capture) begin
      out_none_r <= !best.vld;
      if (best.vld) begin
        out_tdata_r <= {6'd0, best.dist_val, alpha_r, color_rd, best.idx, pidx_r};
      end else begin
        out_tdata_r <= {6'd0, DIST_MAX, alpha_r, COLOR_W'(0), LM_IDX_W'(0), pidx_r};
      end
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_none_r;

endmodule
`default_nettype wire

### hw/rtl/nlc_chk.sv
`default_nettype none
module nlc_chk import nlc_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [0:0]             out_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one point at a time: no request taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input open while result pending");

  // an empty landmark set gives index 0, colour 0 and full distance
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[97:58] == DIST_MAX) && (out_tdata[25:20] == '0) && (out_tdata[49:26] == '0))
    else $error("bad result for no landmarks");

  // input reopens right after a result is taken
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready && !out_tvalid)
    else $error("input not reopened after result");

endmodule

bind nearest_landmark_classifier_top nlc_chk u_nlc_chk (.*);
`default_nettype wire

### dv/nearest_landmark_classifier_top_tb.sv
module nearest_landmark_classifier_top_tb;
  import nlc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = LANDMARKS_MAX + 16;
  localparam int RANDOM_REQUESTS = 720;
  localparam int CYCLE_LIMIT     = 1500000;

  // every landmark is loaded in the low dimensions, the first few in all of them
  localparam int PRELOAD_DIMS   = 6;
  localparam int WIDE_LANDMARKS = 4;

  // result field offsets in out_tdata
  localparam int LM_LSB    = PIDX_W;
  localparam int COLOR_LSB = LM_LSB + LM_IDX_W;
  localparam int ALPHA_LSB = COLOR_LSB + COLOR_W;
  localparam int DIST_LSB  = ALPHA_LSB + ALPHA_W;

  typedef struct {
    logic [MODE_W-1:0]            mode;
    logic [LM_IDX_W-1:0]          lm;
    logic [DIM_W-1:0]             dim;
    logic signed [COORD_BITS-1:0] coord;
    logic [COLOR_W-1:0]           color;
    logic [PIDX_W-1:0]            pidx;
  } request_t;

  typedef struct {
    logic [PIDX_W-1:0]   pidx;
    logic [LM_IDX_W-1:0] lm;
    logic [COLOR_W-1:0]  color;
    logic [ALPHA_W-1:0]  alpha;
    logic [DIST_W-1:0]   dist_val;
    logic                none;
  } classification_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic [MODE_W-1:0]     in_tuser   = MODE_LOAD_COORD;
  logic                  in_tvalid  = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [1:0]            cfg_index  = CFG_DIMS;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tvalid;

  // shadow of the block: stores, running sums and registers
  logic signed [COORD_BITS-1:0] lm_coords [LANDMARKS_MAX][DIMS_MAX] = '{default: '0};
  logic [COLOR_W-1:0]           lm_colors [LANDMARKS_MAX] = '{default: '0};
  logic [DIST_W-1:0]            dist_sums [LANDMARKS_MAX] = '{default: '0};
  logic [CFG_DIMS_W-1:0]        dims_reg  = 6'd2;
  logic [CFG_LMS_W-1:0]         lms_reg   = 7'd0;
  logic [ALPHA_W-1:0]           alpha_reg = 8'd255;

  classification_t pending_classes [$];

  int          errors            = 0;
  int          points_classified = 0;
  int          loads_applied     = 0;
  int          ignored_requests  = 0;
  int          settings_written  = 0;
  int unsigned applied_requests  = 0;
  int unsigned cycle_count       = 0;
  bit          steady_input      = 1'b0;

  nearest_landmark_classifier_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stalled, %0d results still pending", $time, pending_classes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned dims_in_effect();
    if (dims_reg == 0) return 1;
    if (dims_reg > DIMS_MAX) return DIMS_MAX;
    return dims_reg;
  endfunction

  function automatic int unsigned landmarks_in_effect();
    if (lms_reg > LANDMARKS_MAX) return LANDMARKS_MAX;
    return lms_reg;
  endfunction

  function automatic logic [DIST_W-1:0] squared_gap(input logic signed [COORD_BITS-1:0] a,
                                                    input logic signed [COORD_BITS-1:0] b);
    longint          diff;
    longint unsigned mag;
    longint unsigned sq;
    diff = longint'(a) - longint'(b);
    mag  = (diff < 0) ? -diff : diff;
    if (mag > 64'd1048575) return DIST_MAX;
    sq = mag * mag;
    return (sq > DIST_MAX) ? DIST_MAX : sq[DIST_W-1:0];
  endfunction

  // apply one request to the shadow; returns 0 when the block ignores it
  function automatic bit classify_request(input request_t r);
    classification_t res;
    logic [DIST_W:0] sum;
    int unsigned     nd;
    int unsigned     na;
    int unsigned     best;
    case (r.mode)
      MODE_LOAD_COORD: begin
        lm_coords[r.lm][r.dim] = r.coord;
        loads_applied++;
        return 1'b1;
      end
      MODE_LOAD_COLOR: begin
        lm_colors[r.lm] = r.color;
        loads_applied++;
        return 1'b1;
      end
      MODE_POINT: ;
      default: begin
        ignored_requests++;
        return 1'b0;
      end
    endcase
    nd = dims_in_effect();
    if (r.dim >= nd) begin
      ignored_requests++;
      return 1'b0;
    end
    for (int i = 0; i < LANDMARKS_MAX; i++) begin
      sum = {1'b0, dist_sums[i]} + squared_gap(lm_coords[i][r.dim], r.coord);
      if (r.dim == 0)
        dist_sums[i] = squared_gap(lm_coords[i][r.dim], r.coord);
      else
        dist_sums[i] = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
    end
    if (r.dim != nd - 1) return 1'b1;
    na        = landmarks_in_effect();
    res.pidx  = r.pidx;
    res.alpha = alpha_reg;
    if (na == 0) begin
      res.lm       = '0;
      res.color    = '0;
      res.dist_val = DIST_MAX;
      res.none     = 1'b1;
    end else begin
      // strict compare keeps the lowest index on a tie
      best = 0;
      for (int i = 1; i < na; i++)
        if (dist_sums[i] < dist_sums[best]) best = i;
      res.lm       = LM_IDX_W'(best);
      res.color    = lm_colors[best];
      res.dist_val = dist_sums[best];
      res.none     = 1'b0;
    end
    pending_classes.push_back(res);
    dist_sums = '{default: '0};
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    classification_t want;
    if (pending_classes.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending, expected none actual tdata %h tuser %b",
               $time, out_tdata, out_tuser);
    end else begin
      want = pending_classes.pop_front();
      compare_field("point_index", want.pidx, out_tdata[PIDX_W-1:0]);
      compare_field("nearest_index", want.lm, out_tdata[LM_LSB +: LM_IDX_W]);
      compare_field("nearest_color", want.color, out_tdata[COLOR_LSB +: COLOR_W]);
      compare_field("alpha", want.alpha, out_tdata[ALPHA_LSB +: ALPHA_W]);
      compare_field("nearest_distance", want.dist_val, out_tdata[DIST_LSB +: DIST_W]);
      compare_field("no_landmarks", want.none, out_tuser[0]);
      points_classified++;
    end
  endtask

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) check_result();

  // receiver: mostly ready, with short and occasional long stalls
  initial begin : receiver_stalls
    int unsigned gap;
    int unsigned run;
    @(posedge clk);
    forever begin
      gap = idle_gap();
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 10);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  function automatic request_t noise_request(input logic [MODE_W-1:0] mode);
    request_t r;
    r.mode  = mode;
    r.lm    = LM_IDX_W'($urandom);
    r.dim   = DIM_W'($urandom);
    r.coord = COORD_BITS'($urandom);
    r.color = COLOR_W'($urandom);
    r.pidx  = PIDX_W'($urandom);
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_coord(input int unsigned dim);
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      // copy a landmark to force zero distances and ties
      2:       return lm_coords[$urandom_range(0, LANDMARKS_MAX - 1)][dim];
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_request(input request_t r);
    int unsigned gap;
    gap = steady_input ? 0 : idle_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {1'b0, r.pidx, r.color, r.coord, r.dim, r.lm};
    in_tuser  <= r.mode;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (classify_request(r)) applied_requests++;
  endtask

  task automatic load_coord(input int unsigned lm, input int unsigned dim,
                            input logic signed [COORD_BITS-1:0] value);
    request_t r;
    r       = noise_request(MODE_LOAD_COORD);
    r.lm    = LM_IDX_W'(lm);
    r.dim   = DIM_W'(dim);
    r.coord = value;
    send_request(r);
  endtask

  task automatic load_color(input int unsigned lm, input logic [COLOR_W-1:0] value);
    request_t r;
    r       = noise_request(MODE_LOAD_COLOR);
    r.lm    = LM_IDX_W'(lm);
    r.color = value;
    send_request(r);
  endtask

  task automatic send_coord(input logic [PIDX_W-1:0] pidx, input int unsigned dim,
                            input logic signed [COORD_BITS-1:0] value);
    request_t r;
    r       = noise_request(MODE_POINT);
    r.pidx  = pidx;
    r.dim   = DIM_W'(dim);
    r.coord = value;
    send_request(r);
  endtask

  // dimensions 0..count-1 of one point in order, random content
  task automatic send_point(input int unsigned count);
    logic [PIDX_W-1:0] pidx;
    pidx = PIDX_W'($urandom);
    for (int d = 0; d < count; d++) send_coord(pidx, d, pick_coord(d));
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] dims, input logic [CFG_DATA_W-1:0] lms,
                            input logic [CFG_DATA_W-1:0] alpha);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIMS;
    cfg_wdata <= dims;
    @(posedge clk);
    cfg_index <= CFG_LMS;
    cfg_wdata <= lms;
    @(posedge clk);
    cfg_index <= CFG_ALPHA;
    cfg_wdata <= alpha;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dims_reg  = dims[CFG_DIMS_W-1:0];
    lms_reg   = lms[CFG_LMS_W-1:0];
    alpha_reg = alpha[ALPHA_W-1:0];
    settings_written++;
  endtask

  // reset registers: two dimensions, no landmarks, opaque
  task automatic test_reset_defaults();
    send_coord(20'h00001, 0, 16'sh0100);
    send_coord(20'h00001, 2, 16'sh0200);
    send_coord(20'h00001, 1, 16'sh0300);
  endtask

  // fill every entry an active landmark can be read at: all colours, the low dimensions
  // of every landmark and all dimensions of the few landmarks that wide points search
  task automatic preload_landmarks();
    for (int lm = 0; lm < LANDMARKS_MAX; lm++) begin
      load_color(lm, COLOR_W'($urandom));
      for (int d = 0; d < DIMS_MAX; d++)
        if (d < PRELOAD_DIMS || lm < WIDE_LANDMARKS) load_coord(lm, d, COORD_BITS'($urandom));
    end
  endtask

  task automatic test_extremes_and_ties();
    set_config(8'd1, 8'd64, 8'd0);
    load_coord(0, 0, 16'sh8000);
    load_coord(LANDMARKS_MAX - 1, 0, 16'sh7FFF);
    load_color(0, 24'h000000);
    load_color(LANDMARKS_MAX - 1, 24'hFFFFFF);
    send_coord(20'hFFFFF, 0, 16'sh7FFF);
    send_coord(20'h00000, 0, 16'sh8000);
    // equal landmarks: the lower index must win
    load_coord(7, 0, 16'sh1234);
    load_coord(20, 0, 16'sh1234);
    send_coord(20'h5A5A5, 0, 16'sh1234);
  endtask

  task automatic test_register_limits();
    // zero dimensions act as one, landmark count clamps to the maximum
    set_config(8'd0, 8'hFF, 8'hA5);
    send_coord(20'hA5A5A, 0, 16'sh4000);
    send_coord(20'hA5A5A, 1, 16'sh4000);
    // oversized dimension count clamps: last dimension alone ends a point
    set_config(8'hFF, 8'(WIDE_LANDMARKS), 8'h00);
    send_coord(20'h12345, DIMS_MAX - 1, 16'shC000);
  endtask

  task automatic test_point_restart();
    set_config(8'd3, 8'd1, 8'h5A);
    load_coord(0, 1, 16'sh8000);
    load_coord(0, 2, 16'sh8000);
    send_coord(20'h0000F, 0, 16'sh7FFF);
    send_coord(20'h0000F, 1, 16'sh7FFF);
    // dimension zero again drops the partial sums
    send_coord(20'h000F0, 0, 16'sh7FFF);
    send_coord(20'h000F0, 1, 16'sh7FFF);
    send_coord(20'h000F0, 2, 16'sh7FFF);
    send_request(noise_request(MODE_UNUSED));
    send_coord(20'h00F00, 1, 16'sh0001);
    send_coord(20'h00F00, 2, 16'shFFFF);
  endtask

  task automatic test_random_traffic();
    request_t                r;
    int unsigned             start;
    int unsigned             nd;
    int unsigned             choice;
    logic [CFG_DATA_W-1:0]   dims_w;
    logic [CFG_DATA_W-1:0]   lms_w;
    logic [CFG_DATA_W-1:0]   alpha_w;
    start = applied_requests;
    while (applied_requests - start < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0:       dims_w = 8'd0;
        1:       dims_w = 8'd32;
        2:       dims_w = 8'($urandom_range(33, 255));
        default: dims_w = 8'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       lms_w = 8'd0;
        1:       lms_w = 8'd64;
        2:       lms_w = 8'($urandom_range(65, 255));
        3:       lms_w = 8'd1;
        default: lms_w = 8'($urandom_range(2, 64));
      endcase
      // wide points only search the fully loaded landmarks
      if (dims_w[CFG_DIMS_W-1:0] > CFG_DIMS_W'(PRELOAD_DIMS) &&
          lms_w[CFG_LMS_W-1:0] > CFG_LMS_W'(WIDE_LANDMARKS))
        lms_w = 8'($urandom_range(0, WIDE_LANDMARKS));
      case ($urandom_range(0, 5))
        0:       alpha_w = 8'd0;
        1:       alpha_w = 8'd255;
        default: alpha_w = 8'($urandom);
      endcase
      set_config(dims_w, lms_w, alpha_w);
      steady_input = ($urandom_range(0, 4) == 0);
      nd = dims_in_effect();
      repeat ($urandom_range(2, 10)) begin
        choice = $urandom_range(0, 19);
        if (choice < 14) begin
          send_point(nd);
        end else if (choice < 17) begin
          r = noise_request(($urandom_range(0, 1) == 0) ? MODE_LOAD_COORD : MODE_LOAD_COLOR);
          r.coord = pick_coord(r.dim);
          if ($urandom_range(0, 7) == 0) r.color = ($urandom_range(0, 1) == 0) ? '0 : '1;
          send_request(r);
        end else if (choice == 17) begin
          send_request(noise_request(MODE_UNUSED));
        end else if (choice == 18) begin
          // a dimension past the end of the point, or a lone out-of-order one
          r = noise_request(MODE_POINT);
          if (nd < DIMS_MAX && $urandom_range(0, 1) == 0)
            r.dim = DIM_W'($urandom_range(nd, DIMS_MAX - 1));
          send_request(r);
        end else if (nd > 1) begin
          send_point($urandom_range(1, nd - 1));
        end
      end
    end
    steady_input = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    preload_landmarks();
    test_extremes_and_ties();
    test_register_limits();
    test_point_restart();
    test_random_traffic();
    drain_and_settle();
    $display("Classified %0d points under %0d register settings after %0d landmark loads;",
             points_classified, settings_written, loads_applied);
    $display("%0d requests were dropped by the block as unused mode or stray dimension.",
             ignored_requests);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
